### rtl/lcpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcpc_pkg;

  localparam int NumLeds      = 8;
  localparam int LedW         = $clog2(NumLeds);
  localparam int NumSpeeds    = 10;
  localparam int SpeedW       = 4;
  localparam int NumStyles    = 5;
  localparam int StyleW       = 3;
  localparam int NumKeys      = 3;
  localparam int HoldW        = 9;
  localparam int ElapsedW     = 16;
  localparam int DebounceW    = 8;
  localparam int TickW        = 10;
  localparam int PeriodW      = TickW + SpeedW + 1;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 10;
  localparam int RandomStride = 37;
  localparam int MaxRandomLit = 3;

  localparam int KeyRun   = 0;
  localparam int KeySpeed = 1;
  localparam int KeyStyle = 2;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_SPEED_BASE = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_SPEED_STEP = CfgIdxW'(2);

  localparam logic [StyleW-1:0] STYLE_CHASER    = StyleW'(0);
  localparam logic [StyleW-1:0] STYLE_SWEEP_OFF = StyleW'(1);
  localparam logic [StyleW-1:0] STYLE_TO_MIDDLE = StyleW'(2);
  localparam logic [StyleW-1:0] STYLE_TO_ENDS   = StyleW'(3);
  localparam logic [StyleW-1:0] STYLE_RANDOM    = StyleW'(4);

  localparam logic [DebounceW-1:0] DEBOUNCE_RESET = DebounceW'(20);
  localparam logic [TickW-1:0]     BASE_RESET     = TickW'(50);
  localparam logic [TickW-1:0]     STEP_RESET     = TickW'(50);
  localparam logic [SpeedW-1:0]    SPEED_RESET    = SpeedW'(4);

  typedef struct packed {
    logic             last_raw;
    logic             stable;
    logic [HoldW-1:0] hold;
  } key_track_t;

  function automatic logic [StyleW-1:0] next_style(input logic [StyleW-1:0] s);
    logic [StyleW:0] n;
    n = {1'b0, s} + (StyleW+1)'(1);
    if (n >= (StyleW+1)'(NumStyles)) begin
      n = n - (StyleW+1)'(NumStyles);
    end
    return n[StyleW-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/led_chaser_pattern_controller.sv
// LED chaser pattern controller.
// Each input item is one millisecond tick that carries the raw levels of the run,
// speed and style keys. Items enter on in_valid_i and are accepted at a rising
// edge where in_valid_i is high and in_stall_o is low. Each accepted item yields
// exactly one result item (LED pattern, run flag, style and speed level) on
// out_valid_o in the next cycle, taken at an edge where out_stall_i is low.
// Throughput is one item per cycle unless the receiver stalls: the whole tick
// update is a single pass of logic from the state registers back into them, and
// those registers are the result register. A new item is taken while the current
// result is being taken in the same cycle. While the receiver stalls a pending
// result, the result holds and in_stall_o is raised, so no item is accepted.
// Configuration writes use cfg_valid_i and cfg_ready_o, which is always high;
// index 0 sets the debounce time, 1 the base period, 2 the per-level period
// step, and any other index is ignored. Write them only while the block is idle.
// Reset restores the register defaults (20, 50, 50), running mode, speed level
// four, style zero, all LEDs off and no pending result.
`timescale 1ns / 1ps
`default_nettype none

module led_chaser_pattern_controller
  import lcpc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                run_key_i,
  input  wire logic                speed_key_i,
  input  wire logic                style_key_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [NumLeds-1:0]       led_pattern_o,
  output logic                     is_running_o,
  output logic [StyleW-1:0]        style_now_o,
  output logic [SpeedW-1:0]        speed_level_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic                 in_accept;
  logic                 out_valid_q;
  logic [DebounceW-1:0] debounce_q;
  logic [TickW-1:0]     base_q;
  logic [TickW-1:0]     step_q;

  key_track_t           key_q [NumKeys];
  key_track_t           key_d [NumKeys];
  logic                 run_q, run_d;
  logic [SpeedW-1:0]    speed_q, speed_d;
  logic [StyleW-1:0]    style_q, style_d;
  logic [LedW-1:0]      pos_q, pos_d;
  logic                 refill_q, refill_d;
  logic [ElapsedW-1:0]  elapsed_q, elapsed_d;
  logic [LedW-1:0]      tick8_q, tick8_d;
  logic [1:0]           tick3_q, tick3_d;
  logic [NumLeds-1:0]   led_q, led_d;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o   = out_valid_q;
  assign led_pattern_o = led_q;
  assign is_running_o  = run_q;
  assign style_now_o   = style_q;
  assign speed_level_o = speed_q;

  always_comb begin
    logic [NumKeys-1:0]  raw;
    logic [NumKeys-1:0]  press;
    logic [ElapsedW-1:0] el;
    logic [SpeedW:0]     speed_inc;
    logic [PeriodW-1:0]  period;
    logic [LedW-1:0]     p;
    logic [LedW:0]       p_inc;
    logic [LedW-1:0]     idx;

    raw       = {style_key_i, speed_key_i, run_key_i};
    press     = '0;
    speed_inc = '0;
    idx       = '0;

    tick8_d = tick8_q + LedW'(1);
    tick3_d = (tick3_q >= 2'd2) ? 2'd0 : tick3_q + 2'd1;
    el      = (elapsed_q == '1) ? elapsed_q : elapsed_q + ElapsedW'(1);

    for (int k = 0; k < NumKeys; k++) begin
      key_d[k] = key_q[k];
      if (raw[k] != key_q[k].last_raw) begin
        key_d[k].hold     = '0;
        key_d[k].last_raw = raw[k];
      end else if (key_q[k].hold != '1) begin
        key_d[k].hold = key_q[k].hold + HoldW'(1);
      end
      if ((key_d[k].hold > {1'b0, debounce_q}) && (raw[k] != key_q[k].stable)) begin
        key_d[k].stable = raw[k];
        press[k]        = raw[k];
      end
    end

    run_d    = run_q;
    led_d    = led_q;
    speed_d  = speed_q;
    style_d  = style_q;
    pos_d    = pos_q;
    refill_d = refill_q;

    if (press[KeyRun]) begin
      run_d = ~run_q;
      if (run_q) begin
        led_d = '0;
      end
    end
    if (press[KeySpeed]) begin
      speed_inc = {1'b0, speed_q} + (SpeedW+1)'(1);
      speed_d   = (speed_inc >= (SpeedW+1)'(NumSpeeds)) ? '0 : speed_inc[SpeedW-1:0];
    end
    if (press[KeyStyle]) begin
      style_d = next_style(style_q);
      pos_d   = '0;
    end

    period = PeriodW'(base_q) + PeriodW'(step_q) * PeriodW'(speed_d);
    p      = pos_d;
    p_inc  = {1'b0, p} + (LedW+1)'(1);
    elapsed_d = el;

    if (run_d && (el >= ElapsedW'(period))) begin
      elapsed_d = '0;
      unique case (style_d)
        STYLE_CHASER: begin
          led_d    = '0;
          led_d[p] = 1'b1;
          pos_d    = p_inc[LedW-1:0];
        end
        STYLE_SWEEP_OFF: begin
          if (refill_d) begin
            led_d    = '1;
            refill_d = 1'b0;
          end
          led_d[p] = 1'b0;
          pos_d    = p_inc[LedW-1:0];
          if (p_inc[LedW-1:0] == '0) begin
            refill_d = 1'b1;
          end
        end
        STYLE_TO_MIDDLE: begin
          led_d    = '0;
          led_d[p] = 1'b1;
          led_d[LedW'(NumLeds - 1) - p] = 1'b1;
          pos_d = (p_inc >= (LedW+1)'(NumLeds / 2)) ? '0 : p_inc[LedW-1:0];
        end
        STYLE_TO_ENDS: begin
          led_d = '0;
          if (p < LedW'(NumLeds / 2)) begin
            led_d[LedW'(NumLeds / 2 - 1) - p] = 1'b1;
            led_d[LedW'(NumLeds / 2) + p]     = 1'b1;
          end
          pos_d = (p_inc >= (LedW+1)'(NumLeds / 2)) ? '0 : p_inc[LedW-1:0];
        end
        STYLE_RANDOM: begin
          led_d = '0;
          for (int i = 0; i < MaxRandomLit; i++) begin
            idx = tick8_d + LedW'(i * RandomStride);
            if (2'(i) <= tick3_d) begin
              led_d[idx] = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      base_q     <= BASE_RESET;
      step_q     <= STEP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE:   debounce_q <= cfg_data_i[DebounceW-1:0];
        CFG_SPEED_BASE: base_q     <= cfg_data_i[TickW-1:0];
        CFG_SPEED_STEP: step_q     <= cfg_data_i[TickW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumKeys; k++) begin
        key_q[k] <= '0;
      end
      run_q     <= 1'b1;
      speed_q   <= SPEED_RESET;
      style_q   <= STYLE_CHASER;
      pos_q     <= '0;
      refill_q  <= 1'b1;
      elapsed_q <= '0;
      tick8_q   <= '0;
      tick3_q   <= '0;
      led_q     <= '0;
    end else if (in_accept) begin
      for (int k = 0; k < NumKeys; k++) begin
        key_q[k] <= key_d[k];
      end
      run_q     <= run_d;
      speed_q   <= speed_d;
      style_q   <= style_d;
      pos_q     <= pos_d;
      refill_q  <= refill_d;
      elapsed_q <= elapsed_d;
      tick8_q   <= tick8_d;
      tick3_q   <= tick3_d;
      led_q     <= led_d;
    end
  end

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("Input stalled without a pending result.");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("Accepted item produced no result.");

  a_paused_leds_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> (led_q == '0))
    else $error("LEDs lit while paused.");

  a_speed_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_q < SpeedW'(NumSpeeds))
    else $error("Speed level out of range.");

  a_style_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    style_q < StyleW'(NumStyles))
    else $error("Style out of range.");

endmodule

`default_nettype wire
